@@ rtl/core/motor_pwm_duty_compensator_assert.svh @@
// Assertion macros used by the duty compensator top level.
`ifndef MOTOR_PWM_DUTY_COMPENSATOR_ASSERT_SVH
`define MOTOR_PWM_DUTY_COMPENSATOR_ASSERT_SVH

// Same-cycle implication check.
`define MPDC_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("motor_pwm_duty_compensator: same-cycle check failed");

// Next-cycle implication check.
`define MPDC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("motor_pwm_duty_compensator: next-cycle check failed");

`endif

@@ rtl/core/mpdc_pkg.sv @@
// Types and constants of the PWM duty compensator.
package mpdc_pkg;

   localparam int unsigned DUTY_WIDTH      = 8;
   localparam int unsigned VOLTAGE_WIDTH   = 12;
   localparam int unsigned COMPARE_WIDTH   = 16;
   localparam int unsigned FREQ_WIDTH      = 17;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned PCT_STEPS       = 17;
   localparam int unsigned PCT_WIDTH       = 7;
   localparam int unsigned PCT_FULL        = 100;
   localparam int unsigned MILLI_SCALE     = 1000;
   localparam int unsigned CMD_LIMIT       = 100;
   localparam int unsigned DEFAULT_FREQ_HZ = 18000;
   localparam int unsigned RECIP_100       = 41943;
   localparam int unsigned RECIP_WIDTH     = 16;
   localparam int unsigned RECIP_SHIFT     = 22;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INVERT = 2'd0,
      CSR_BRAKE  = 2'd1,
      CSR_FREQ   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic csr_write;
      logic accept_item;
      logic load_low;
      logic div_step;
      logic period_save;
      logic scale;
      logic recip;
      logic correct;
      logic correct_low;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic same_command;
      logic brake;
      logic freq_index;
   } dp_status_type;

endpackage

@@ rtl/core/mpdc_channels.sv @@
// Handshake channel interfaces for items, results and register writes.
interface mpdc_req_if;
   import mpdc_pkg::*;
   logic                            valid;
   logic                            ready;
   logic signed [DUTY_WIDTH-1:0]    duty_command;
   logic        [VOLTAGE_WIDTH-1:0] supply_voltage;
   modport source (output valid, duty_command, supply_voltage, input ready);
   modport sink (input valid, duty_command, supply_voltage, output ready);
endinterface

interface mpdc_rsp_if;
   import mpdc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     phase_forward;
   logic [COMPARE_WIDTH-1:0] high_compare;
   logic [COMPARE_WIDTH-1:0] low_compare;
   modport source (output valid, phase_forward, high_compare, low_compare, input ready);
   modport sink (input valid, phase_forward, high_compare, low_compare, output ready);
endinterface

interface mpdc_csr_if;
   import mpdc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [FREQ_WIDTH-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/motor_pwm_duty_compensator.sv @@
// Top level of the H-bridge PWM duty compensator with supply voltage scaling.
//
// Items arrive on req_channel (signed duty command, supply voltage); results
// leave on rsp_channel (phase line, high-side and low-side compare values).
// Register writes arrive on csr_channel: index 0 inverts the direction,
// index 1 selects brake mode, index 2 sets the PWM frequency in hertz.
// An item whose effective command equals the stored clamped command is taken
// in the idle state and yields no result. Any other item computes the
// high-side compare value in coast mode and both values in brake mode, then
// loads the output register: each compare value needs one 17-step pass of the
// serial divider, then a multiply by the period and a reciprocal divide by 100.
// A frequency write runs the same divider for one step per bit of the timer
// clock constant, then saves the period, and neither channel accepts during that time.
// Reset selects inversion off, brake on, 18000 Hz and a stored command of zero.
// A finished result waits in the output register while the receiver stalls;
// the next item is accepted meanwhile and held back at delivery until the
// register is free.
module motor_pwm_duty_compensator #(
   parameter int unsigned TIMER_CLOCK_HZ = 48000000
) (
   input logic        clock,
   input logic        reset,
   mpdc_req_if.sink   req_channel,
   mpdc_rsp_if.source rsp_channel,
   mpdc_csr_if.sink   csr_channel
);
   import mpdc_pkg::*;

`include "motor_pwm_duty_compensator_assert.svh"

   localparam int unsigned DIV_WIDTH = $clog2(TIMER_CLOCK_HZ + 1);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          req_accept;
   logic          csr_accept;
   logic          freq_accept;

   mpdc_controller #(
      .DIV_WIDTH (DIV_WIDTH)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .csr_valid (csr_channel.valid),
      .csr_ready (csr_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   mpdc_datapath #(
      .TIMER_CLOCK_HZ (TIMER_CLOCK_HZ),
      .DIV_WIDTH      (DIV_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .duty_command   (req_channel.duty_command),
      .supply_voltage (req_channel.supply_voltage),
      .csr_index      (csr_channel.index),
      .csr_data       (csr_channel.data),
      .phase_forward  (rsp_channel.phase_forward),
      .high_compare   (rsp_channel.high_compare),
      .low_compare    (rsp_channel.low_compare)
   );

   assign req_accept  = req_channel.valid && req_channel.ready;
   assign csr_accept  = csr_channel.valid && csr_channel.ready;
   assign freq_accept = csr_accept && (csr_channel.index == CSR_FREQ);

   `MPDC_ASSERT_IMPL(a_no_dual_accept, clock, reset, req_accept, !csr_accept)
   `MPDC_ASSERT_NEXT(a_freq_write_busy, clock, reset, freq_accept, !req_channel.ready && !csr_channel.ready)
   `MPDC_ASSERT_IMPL(a_deliver_frees, clock, reset, $rose(rsp_channel.valid), csr_channel.ready)

endmodule

@@ rtl/core/mpdc_controller.sv @@
// Sequencer that steps the datapath through one item or one period update.
module mpdc_controller #(
   parameter int unsigned DIV_WIDTH = 26
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mpdc_pkg::dp_cmd_type   cmd,
   input  mpdc_pkg::dp_status_type status
);
   import mpdc_pkg::*;

   localparam int unsigned CNT_WIDTH = $clog2(DIV_WIDTH);
   localparam logic [CNT_WIDTH-1:0] PERIOD_LAST = CNT_WIDTH'(DIV_WIDTH - 1);
   localparam logic [CNT_WIDTH-1:0] PCT_LAST    = CNT_WIDTH'(PCT_STEPS - 1);

   typedef enum logic [7:0] {
      ST_IDLE        = 8'b0000_0001,
      ST_PERIOD_DIV  = 8'b0000_0010,
      ST_PERIOD_SAVE = 8'b0000_0100,
      ST_PCT_DIV     = 8'b0000_1000,
      ST_SCALE       = 8'b0001_0000,
      ST_RECIP       = 8'b0010_0000,
      ST_CORRECT     = 8'b0100_0000,
      ST_DELIVER     = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 pass_low_ff, pass_low_in;
   logic                 out_valid_ff, out_valid_in;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pass_low_in = pass_low_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      csr_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               cmd.csr_write = 1'b1;
               if (status.freq_index) begin
                  cnt_in   = '0;
                  state_in = ST_PERIOD_DIV;
               end
            end else if (req_valid) begin
               cmd.accept_item = 1'b1;
               if (!status.same_command) begin
                  cnt_in      = '0;
                  pass_low_in = 1'b0;
                  state_in    = ST_PCT_DIV;
               end
            end
         end
         ST_PERIOD_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == PERIOD_LAST) begin
               state_in = ST_PERIOD_SAVE;
            end
         end
         ST_PERIOD_SAVE: begin
            cmd.period_save = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_PCT_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == PCT_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_RECIP;
         end
         ST_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = ST_CORRECT;
         end
         ST_CORRECT: begin
            cmd.correct     = 1'b1;
            cmd.correct_low = pass_low_ff;
            if (!pass_low_ff && status.brake) begin
               cmd.load_low = 1'b1;
               pass_low_in  = 1'b1;
               cnt_in       = '0;
               state_in     = ST_PCT_DIV;
            end else begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pass_low_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_low_ff  <= pass_low_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

@@ rtl/core/mpdc_datapath.sv @@
// Datapath: registers, serial divider, scaling multipliers and output register.
module mpdc_datapath #(
   parameter int unsigned TIMER_CLOCK_HZ = 48000000,
   parameter int unsigned DIV_WIDTH      = 26
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mpdc_pkg::dp_cmd_type                   cmd,
   output mpdc_pkg::dp_status_type                status,
   input  logic signed [mpdc_pkg::DUTY_WIDTH-1:0] duty_command,
   input  logic [mpdc_pkg::VOLTAGE_WIDTH-1:0]     supply_voltage,
   input  logic [mpdc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mpdc_pkg::FREQ_WIDTH-1:0]        csr_data,
   output logic                                   phase_forward,
   output logic [mpdc_pkg::COMPARE_WIDTH-1:0]     high_compare,
   output logic [mpdc_pkg::COMPARE_WIDTH-1:0]     low_compare
);
   import mpdc_pkg::*;

   localparam int unsigned CMD_WIDTH  = DUTY_WIDTH + 1;
   localparam int unsigned PROD_WIDTH = COMPARE_WIDTH + PCT_WIDTH;
   localparam int unsigned EST_WIDTH  = PROD_WIDTH + RECIP_WIDTH;
   localparam int unsigned QEST_WIDTH = EST_WIDTH - RECIP_SHIFT;
   localparam int unsigned PAD_WIDTH  = DIV_WIDTH - PCT_STEPS;

   localparam logic signed [CMD_WIDTH-1:0] CMD_HI = CMD_WIDTH'(CMD_LIMIT);
   localparam logic signed [CMD_WIDTH-1:0] CMD_LO = -CMD_HI;
   localparam logic [PCT_STEPS-1:0] LOW_DIVIDEND = PCT_STEPS'(PCT_FULL * MILLI_SCALE);
   localparam logic [PCT_WIDTH-1:0] PCT_MAX = PCT_WIDTH'(PCT_FULL);
   localparam logic [DIV_WIDTH-1:0] DIV_TIMER = DIV_WIDTH'(TIMER_CLOCK_HZ);
   localparam logic [DIV_WIDTH-1:0] DIV_PERIOD_MAX = DIV_WIDTH'((1 << COMPARE_WIDTH) - 1);
   localparam longint unsigned RESET_QUO = TIMER_CLOCK_HZ / DEFAULT_FREQ_HZ;
   localparam logic [COMPARE_WIDTH-1:0] PERIOD_RESET =
      (RESET_QUO == 0) ? '0 :
      ((RESET_QUO - 1) > ((1 << COMPARE_WIDTH) - 1)) ? '1 :
      COMPARE_WIDTH'(RESET_QUO - 1);

   logic                            invert_ff, invert_in;
   logic                            brake_ff, brake_in;
   logic signed [DUTY_WIDTH-1:0]    last_ff, last_in;
   logic [COMPARE_WIDTH-1:0]        period_ff, period_in;
   logic [FREQ_WIDTH-1:0]           rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]            quo_ff, quo_in;
   logic [FREQ_WIDTH-1:0]           divisor_ff, divisor_in;
   logic                            phase_ff;
   logic [PROD_WIDTH-1:0]           prod_ff;
   logic [EST_WIDTH-1:0]            est_ff;
   logic [COMPARE_WIDTH-1:0]        hi_ff, lo_ff;
   logic                            out_phase_ff;
   logic [COMPARE_WIDTH-1:0]        out_high_ff, out_low_ff;

   logic signed [CMD_WIDTH-1:0]     cmd_ext, cmd_eff, last_ext;
   logic        [CMD_WIDTH-1:0]     cmd_neg;
   logic signed [DUTY_WIDTH-1:0]    cmd_clamped;
   logic        [DUTY_WIDTH-1:0]    mag;
   logic        [PCT_STEPS-1:0]     mag_scaled;
   logic        [FREQ_WIDTH:0]      rem_shift, rem_diff;
   logic                            take;
   logic        [PCT_STEPS-1:0]     pct_quo;
   logic        [PCT_WIDTH-1:0]     pct;
   logic        [QEST_WIDTH-1:0]    q_est;
   logic        [PROD_WIDTH-1:0]    q_times, q_rem;
   logic        [QEST_WIDTH-1:0]    q_fix;
   logic        [DIV_WIDTH-1:0]     quo_less;

   assign cmd_ext  = {duty_command[DUTY_WIDTH-1], duty_command};
   assign cmd_eff  = invert_ff ? -cmd_ext : cmd_ext;
   assign last_ext = {last_ff[DUTY_WIDTH-1], last_ff};
   assign cmd_neg  = -cmd_eff;
   assign mag      = cmd_eff[CMD_WIDTH-1] ? cmd_neg[DUTY_WIDTH-1:0]
                                          : cmd_eff[DUTY_WIDTH-1:0];
   assign mag_scaled = PCT_STEPS'(mag) * PCT_STEPS'(MILLI_SCALE);

   always_comb begin
      if (cmd_eff > CMD_HI) begin
         cmd_clamped = CMD_HI[DUTY_WIDTH-1:0];
      end else if (cmd_eff < CMD_LO) begin
         cmd_clamped = CMD_LO[DUTY_WIDTH-1:0];
      end else begin
         cmd_clamped = cmd_eff[DUTY_WIDTH-1:0];
      end
   end

   assign status.same_command = (cmd_eff == last_ext);
   assign status.brake        = brake_ff;
   assign status.freq_index   = (csr_index == CSR_FREQ);

   // One restoring division step a cycle while div_step is set, dividend shifted in from the top.
   assign rem_shift = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign take      = (rem_shift >= {1'b0, divisor_ff});

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (cmd.csr_write && status.freq_index) begin
         rem_in     = '0;
         quo_in     = DIV_TIMER;
         divisor_in = csr_data;
      end else if (cmd.accept_item) begin
         rem_in     = '0;
         quo_in     = {mag_scaled, {PAD_WIDTH{1'b0}}};
         divisor_in = FREQ_WIDTH'(supply_voltage);
      end else if (cmd.load_low) begin
         rem_in = '0;
         quo_in = {LOW_DIVIDEND, {PAD_WIDTH{1'b0}}};
      end else if (cmd.div_step) begin
         rem_in = take ? rem_diff[FREQ_WIDTH-1:0] : rem_shift[FREQ_WIDTH-1:0];
         quo_in = {quo_ff[DIV_WIDTH-2:0], take};
      end
   end

   assign pct_quo = quo_ff[PCT_STEPS-1:0];
   assign pct = ((divisor_ff == '0) || (pct_quo > PCT_STEPS'(PCT_FULL))) ? PCT_MAX
                                                                   : pct_quo[PCT_WIDTH-1:0];

   // Divide by 100: reciprocal estimate is exact or one low, fixed by the remainder.
   assign q_est   = est_ff[EST_WIDTH-1:RECIP_SHIFT];
   assign q_times = PROD_WIDTH'(q_est) * PROD_WIDTH'(PCT_FULL);
   assign q_rem   = prod_ff - q_times;
   assign q_fix   = (q_rem >= PROD_WIDTH'(PCT_FULL)) ? q_est + 1'b1 : q_est;

   assign quo_less = quo_ff - 1'b1;

   always_comb begin
      period_in = period_ff;
      if (cmd.period_save) begin
         if (divisor_ff == '0) begin
            period_in = '1;
         end else if (quo_ff == '0) begin
            period_in = '0;
         end else if (quo_less > DIV_PERIOD_MAX) begin
            period_in = '1;
         end else begin
            period_in = quo_less[COMPARE_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      invert_in = invert_ff;
      brake_in  = brake_ff;
      if (cmd.csr_write) begin
         unique case (csr_index)
            CSR_INVERT: invert_in = csr_data[0];
            CSR_BRAKE:  brake_in  = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      last_in = last_ff;
      if (cmd.accept_item && !status.same_command) begin
         last_in = cmd_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b0;
         brake_ff  <= 1'b1;
         last_ff   <= '0;
         period_ff <= PERIOD_RESET;
      end else begin
         invert_ff <= invert_in;
         brake_ff  <= brake_in;
         last_ff   <= last_in;
         period_ff <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      if (cmd.accept_item) begin
         phase_ff <= (cmd_eff > 0);
      end
      if (cmd.scale) begin
         prod_ff <= PROD_WIDTH'(period_ff) * PROD_WIDTH'(pct);
      end
      if (cmd.recip) begin
         est_ff <= EST_WIDTH'(prod_ff) * EST_WIDTH'(RECIP_100);
      end
      if (cmd.correct) begin
         if (cmd.correct_low) begin
            lo_ff <= q_fix[COMPARE_WIDTH-1:0];
         end else begin
            hi_ff <= q_fix[COMPARE_WIDTH-1:0];
         end
      end
      if (cmd.out_load) begin
         out_phase_ff <= phase_ff;
         out_high_ff  <= hi_ff;
         out_low_ff   <= brake_ff ? lo_ff : hi_ff;
      end
   end

   assign phase_forward = out_phase_ff;
   assign high_compare  = out_high_ff;
   assign low_compare   = out_low_ff;

endmodule
